// File: design/imadec_pkg.sv
// Shared types, constants and tables for the IMA ADPCM voice decoder.
`default_nettype none

package imadec_pkg;

   localparam int unsigned STEP_MAX = 88;
   localparam int unsigned IDX_W = 7;
   localparam int unsigned STEP_W = 15;
   localparam int unsigned DIFF_W = 17;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned ENV_W = 8;
   localparam int unsigned VOL_W = 7;
   localparam int unsigned ENV_SHIFT = 8;
   localparam int unsigned VOL_SHIFT = 7;

   localparam logic [VOL_W-1:0] VOL_RESET = 7'd127;
   localparam logic [IDX_W-1:0] IDX_LIMIT = 7'd88;

   // saturation bounds at the width of the predictor sum
   localparam logic signed [18:0] SUM_MAX = 19'sd32767;
   localparam logic signed [18:0] SUM_MIN = -19'sd32768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_ENV,
      ST_VOL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL_ENV,
      ALU_MUL_VOL
   } alu_op_type;

   // step size for each step index
   function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
      logic [STEP_W-1:0] val;
      begin
         case (idx)
            7'd0: val = 15'd7;       7'd1: val = 15'd8;       7'd2: val = 15'd9;
            7'd3: val = 15'd10;      7'd4: val = 15'd11;      7'd5: val = 15'd12;
            7'd6: val = 15'd13;      7'd7: val = 15'd14;      7'd8: val = 15'd16;
            7'd9: val = 15'd17;      7'd10: val = 15'd19;     7'd11: val = 15'd21;
            7'd12: val = 15'd23;     7'd13: val = 15'd25;     7'd14: val = 15'd28;
            7'd15: val = 15'd31;     7'd16: val = 15'd34;     7'd17: val = 15'd37;
            7'd18: val = 15'd41;     7'd19: val = 15'd45;     7'd20: val = 15'd50;
            7'd21: val = 15'd55;     7'd22: val = 15'd60;     7'd23: val = 15'd66;
            7'd24: val = 15'd73;     7'd25: val = 15'd80;     7'd26: val = 15'd88;
            7'd27: val = 15'd97;     7'd28: val = 15'd107;    7'd29: val = 15'd118;
            7'd30: val = 15'd130;    7'd31: val = 15'd143;    7'd32: val = 15'd157;
            7'd33: val = 15'd173;    7'd34: val = 15'd190;    7'd35: val = 15'd209;
            7'd36: val = 15'd230;    7'd37: val = 15'd253;    7'd38: val = 15'd279;
            7'd39: val = 15'd307;    7'd40: val = 15'd337;    7'd41: val = 15'd371;
            7'd42: val = 15'd408;    7'd43: val = 15'd449;    7'd44: val = 15'd494;
            7'd45: val = 15'd544;    7'd46: val = 15'd598;    7'd47: val = 15'd658;
            7'd48: val = 15'd724;    7'd49: val = 15'd796;    7'd50: val = 15'd876;
            7'd51: val = 15'd963;    7'd52: val = 15'd1060;   7'd53: val = 15'd1166;
            7'd54: val = 15'd1282;   7'd55: val = 15'd1411;   7'd56: val = 15'd1552;
            7'd57: val = 15'd1707;   7'd58: val = 15'd1878;   7'd59: val = 15'd2066;
            7'd60: val = 15'd2272;   7'd61: val = 15'd2499;   7'd62: val = 15'd2749;
            7'd63: val = 15'd3024;   7'd64: val = 15'd3327;   7'd65: val = 15'd3660;
            7'd66: val = 15'd4026;   7'd67: val = 15'd4428;   7'd68: val = 15'd4871;
            7'd69: val = 15'd5358;   7'd70: val = 15'd5894;   7'd71: val = 15'd6484;
            7'd72: val = 15'd7132;   7'd73: val = 15'd7845;   7'd74: val = 15'd8630;
            7'd75: val = 15'd9493;   7'd76: val = 15'd10442;  7'd77: val = 15'd11487;
            7'd78: val = 15'd12635;  7'd79: val = 15'd13899;  7'd80: val = 15'd15289;
            7'd81: val = 15'd16818;  7'd82: val = 15'd18500;  7'd83: val = 15'd20350;
            7'd84: val = 15'd22385;  7'd85: val = 15'd24623;  7'd86: val = 15'd27086;
            7'd87: val = 15'd29794;  7'd88: val = 15'd32767;
            default: val = 15'd32767;
         endcase
         return val;
      end
   endfunction

   // signed step index adjustment for the magnitude bits of a code
   function automatic logic signed [7:0] index_move(input logic [2:0] mag);
      logic signed [7:0] mv;
      begin
         case (mag)
            3'd4: mv = 8'sd2;
            3'd5: mv = 8'sd4;
            3'd6: mv = 8'sd6;
            3'd7: mv = 8'sd8;
            default: mv = -8'sd1;
         endcase
         return mv;
      end
   endfunction

endpackage

`default_nettype wire

// File: design/imadec_alu.sv
// Shared arithmetic unit: saturating add/subtract and scale-by-shift multiply.
`default_nettype none

module imadec_alu (
   input  imadec_pkg::alu_op_type           op,
   input  logic signed [imadec_pkg::SAMPLE_W-1:0] opnd_a,
   input  logic [imadec_pkg::DIFF_W-1:0]    opnd_b,
   output logic signed [imadec_pkg::SAMPLE_W-1:0] result
);

   logic signed [18:0] sum;
   logic signed [24:0] prod;
   logic signed [24:0] shifted;

   always_comb begin
      sum = '0;
      prod = '0;
      shifted = '0;
      result = '0;
      case (op)
         imadec_pkg::ALU_ADD,
         imadec_pkg::ALU_SUB: begin
            // widen both sides, then clamp to the 16-bit sample range
            if (op == imadec_pkg::ALU_SUB) begin
               sum = $signed({{3{opnd_a[15]}}, opnd_a}) - $signed({2'b00, opnd_b});
            end else begin
               sum = $signed({{3{opnd_a[15]}}, opnd_a}) + $signed({2'b00, opnd_b});
            end
            if (sum > imadec_pkg::SUM_MAX) begin
               result = 16'sh7FFF;
            end else if (sum < imadec_pkg::SUM_MIN) begin
               result = -16'sh8000;
            end else begin
               result = sum[15:0];
            end
         end
         imadec_pkg::ALU_MUL_ENV,
         imadec_pkg::ALU_MUL_VOL: begin
            // 16 x 9 signed multiply, floor shift; result always fits 16 bits
            prod = $signed({{9{opnd_a[15]}}, opnd_a}) * $signed({17'b0, opnd_b[7:0]});
            if (op == imadec_pkg::ALU_MUL_ENV) begin
               shifted = prod >>> imadec_pkg::ENV_SHIFT;
            end else begin
               shifted = prod >>> imadec_pkg::VOL_SHIFT;
            end
            result = shifted[15:0];
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/ima_adpcm_voice_decoder.sv
// Top level of the IMA ADPCM voice decoder: sequencer, state and result registers.
`default_nettype none

// Decodes one 4-bit IMA ADPCM code per beat into a 16-bit predictor, the new
// step index and the predictor scaled by the envelope level (>>8) and the
// channel volume (>>7). A set restart bit clears predictor and step index
// before the code is decoded. Each code runs through ST_IDLE, which takes the
// beat, then ST_PRED, ST_ENV and ST_VOL, three passes through the single
// shared arithmetic unit (predictor update, envelope multiply, volume
// multiply), and ST_OUT, which hands over the result and waits for rsp_ready.
// req_ready is high only while no code is in flight. The channel volume is
// written through csr_wr_en/csr_wr_data at any idle time and resets to 127.
module ima_adpcm_voice_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_code_nibble,
   input  logic        req_restart,
   input  logic [7:0]  req_env_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_scaled_sample,
   output logic signed [15:0] rsp_predictor_value,
   output logic [6:0]  rsp_step_position,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   imadec_pkg::state_type  state_ff, state_in;
   imadec_pkg::alu_op_type alu_op;

   logic signed [15:0] predictor_ff, predictor_in;
   logic [6:0]         step_index_ff, step_index_in;
   logic signed [15:0] sample_ff, sample_in;
   logic [6:0]         volume_ff, volume_in;
   logic [3:0]         code_ff, code_in;
   logic [7:0]         env_ff, env_in;

   logic               req_fire;
   logic               rsp_fire;
   logic [14:0]        step;
   logic [16:0]        diff;
   logic signed [7:0]  idx_sum;
   logic signed [15:0] alu_a;
   logic [16:0]        alu_b;
   logic signed [15:0] alu_result;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         imadec_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = imadec_pkg::ST_PRED;
            end
         end
         imadec_pkg::ST_PRED: state_in = imadec_pkg::ST_ENV;
         imadec_pkg::ST_ENV:  state_in = imadec_pkg::ST_VOL;
         imadec_pkg::ST_VOL:  state_in = imadec_pkg::ST_OUT;
         imadec_pkg::ST_OUT: begin
            if (rsp_fire) begin
               state_in = imadec_pkg::ST_IDLE;
            end
         end
         default: state_in = imadec_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and shared unit operation
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      alu_op = imadec_pkg::ALU_ADD;
      case (state_ff)
         imadec_pkg::ST_IDLE: req_ready = 1'b1;
         imadec_pkg::ST_PRED: begin
            alu_op = code_ff[3] ? imadec_pkg::ALU_SUB : imadec_pkg::ALU_ADD;
         end
         imadec_pkg::ST_ENV: alu_op = imadec_pkg::ALU_MUL_ENV;
         imadec_pkg::ST_VOL: alu_op = imadec_pkg::ALU_MUL_VOL;
         imadec_pkg::ST_OUT: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // build the difference from the step size and magnitude bits
   always_comb begin
      step = imadec_pkg::step_size(step_index_ff);
      diff = {5'b0, step[14:3]};
      if (code_ff[0]) begin
         diff = diff + {4'b0, step[14:2]};
      end
      if (code_ff[1]) begin
         diff = diff + {3'b0, step[14:1]};
      end
      if (code_ff[2]) begin
         diff = diff + {2'b0, step};
      end
      idx_sum = $signed({1'b0, step_index_ff}) + imadec_pkg::index_move(code_ff[2:0]);
   end

   // steer operands into the shared unit
   always_comb begin
      alu_a = predictor_ff;
      alu_b = diff;
      case (state_ff)
         imadec_pkg::ST_ENV: alu_b = {9'b0, env_ff};
         imadec_pkg::ST_VOL: begin
            alu_a = sample_ff;
            alu_b = {10'b0, volume_ff};
         end
         default: begin
            alu_a = predictor_ff;
         end
      endcase
   end

   imadec_alu u_alu (
      .op     (alu_op),
      .opnd_a (alu_a),
      .opnd_b (alu_b),
      .result (alu_result)
   );

   // next values of the datapath registers
   always_comb begin
      predictor_in = predictor_ff;
      step_index_in = step_index_ff;
      sample_in = sample_ff;
      code_in = code_ff;
      env_in = env_ff;
      volume_in = csr_wr_en ? csr_wr_data : volume_ff;
      case (state_ff)
         imadec_pkg::ST_IDLE: begin
            if (req_fire) begin
               code_in = req_code_nibble;
               env_in = req_env_level;
               if (req_restart) begin
                  predictor_in = '0;
                  step_index_in = '0;
               end
            end
         end
         imadec_pkg::ST_PRED: begin
            predictor_in = alu_result;
            // clamp the new step index to the table range
            if (idx_sum < 8'sd0) begin
               step_index_in = '0;
            end else if (idx_sum > $signed({1'b0, imadec_pkg::IDX_LIMIT})) begin
               step_index_in = imadec_pkg::IDX_LIMIT;
            end else begin
               step_index_in = idx_sum[6:0];
            end
         end
         imadec_pkg::ST_ENV: sample_in = alu_result;
         imadec_pkg::ST_VOL: sample_in = alu_result;
         default: begin
            sample_in = sample_ff;
         end
      endcase
   end

   // control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imadec_pkg::ST_IDLE;
         predictor_ff <= '0;
         step_index_ff <= '0;
         volume_ff <= imadec_pkg::VOL_RESET;
      end else begin
         state_ff <= state_in;
         predictor_ff <= predictor_in;
         step_index_ff <= step_index_in;
         volume_ff <= volume_in;
      end
   end

   // beat payload and working sample
   always_ff @(posedge clock) begin
      code_ff <= code_in;
      env_ff <= env_in;
      sample_ff <= sample_in;
   end

   assign rsp_scaled_sample = sample_ff;
   assign rsp_predictor_value = predictor_ff;
   assign rsp_step_position = step_index_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == imadec_pkg::ST_PRED)
      else $error("accepted beat did not start decoding");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_restart) |=> (predictor_ff == 16'sd0 && step_index_ff == 7'd0))
      else $error("restart did not clear decoder state");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_vol_to_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == imadec_pkg::ST_VOL |=> rsp_valid)
      else $error("result not presented after volume scaling");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      step_index_ff <= imadec_pkg::IDX_LIMIT)
      else $error("step index out of table range");
`endif

endmodule

`default_nettype wire
